// File: design/ffba_pkg.sv
`default_nettype none
package ffba_pkg;
   localparam int MaxBlocks = 64;
   localparam int HeaderBytes = 24;
   localparam int IdxW = $clog2(MaxBlocks);
   localparam int PtrW = IdxW + 1;
   localparam logic [PtrW-1:0] NoneIdx = PtrW'(MaxBlocks);

   localparam logic [2:0] StOk = 3'd0;
   localparam logic [2:0] StZero = 3'd1;
   localparam logic [2:0] StExhausted = 3'd2;
   localparam logic [2:0] StTableFull = 3'd3;
   localparam logic [2:0] StUnknown = 3'd4;

   localparam logic KindAlloc = 1'b0;
   localparam logic KindFree = 1'b1;

   localparam logic [0:0] RegHeapBase = 1'd0;
   localparam logic [0:0] RegHeapLimit = 1'd1;

   typedef struct packed {
      logic kind;
      logic [23:0] request_size;
      logic [31:0] payload_address;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] bytes;
      logic is_free;
      logic [PtrW-1:0] succ;
   } entry_type;
endpackage
`default_nettype wire

// File: design/ffba_table.sv
`default_nettype none
module ffba_table (
   input wire logic clock,
   input wire logic rd_en,
   input wire logic [ffba_pkg::IdxW-1:0] rd_addr,
   output ffba_pkg::entry_type rd_data,
   input wire logic wr_en,
   input wire logic [ffba_pkg::IdxW-1:0] wr_addr,
   input wire ffba_pkg::entry_type wr_data
);
   ffba_pkg::entry_type mem [ffba_pkg::MaxBlocks];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: design/first_fit_block_allocator.sv
`default_nettype none
// channel | ports                          | accept
// req     | start, busy, req_item          | start && !busy
// rsp     | rsp_valid, rsp_item            | rsp_valid (one cycle)
// csr     | psel..pready, APB, regs at 4*i | psel&&penable&&pwrite&&!busy
// An item walks the block list one entry at a time, read and then use;
// a failed allocation checks the heap limit before any free-slot search.
// An append then steps one slot a cycle over the slot-used flags;
// a full table answers StTableFull, the response comes as busy drops.
// Reset is synchronous; the table needs no clearing. The receiver cannot stall.
module first_fit_block_allocator (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire ffba_pkg::req_type req_item,
   output logic rsp_valid,
   output ffba_pkg::rsp_type rsp_item,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [2:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int IW = ffba_pkg::IdxW;
   localparam int PW = ffba_pkg::PtrW;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_RD   = 8'b00000010,
      S_CHK  = 8'b00000100,
      S_SLOT = 8'b00001000,
      S_NRD  = 8'b00010000,
      S_NCHK = 8'b00100000,
      S_WR   = 8'b01000000,
      S_DONE = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] base_ff, base_in, limit_ff, limit_in, brk_ff, brk_in;
   logic [ffba_pkg::MaxBlocks-1:0] used_ff, used_in;
   logic [PW-1:0] first_ff, first_in, last_ff, last_in, cur_ff, cur_in;
   logic [PW-1:0] steps_ff, steps_in, slot_ff, slot_in;
   ffba_pkg::req_type req_ff, req_in;
   ffba_pkg::rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;
   logic [31:0] need_ff, need_in;
   ffba_pkg::entry_type ent_ff, ent_in;
   logic [IW-1:0] cidx_ff, cidx_in;

   logic rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   ffba_pkg::entry_type rd_data, wr_data;
   logic wr2_ff, wr2_in;
   logic [IW-1:0] wa2_ff, wa2_in;
   ffba_pkg::entry_type wd2_ff, wd2_in;

   logic csr_wr;
   logic [32:0] end_sum;
   logic [31:0] hdr_addr;

   ffba_table u_table (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_item = rsp_ff;
   assign prdata = (paddr[2] == ffba_pkg::RegHeapLimit) ? limit_ff : base_ff;
   assign end_sum = {1'b0, brk_ff} + 33'(ffba_pkg::HeaderBytes) + {1'b0, need_ff};
   assign hdr_addr = rd_data.start + 32'(ffba_pkg::HeaderBytes);

   always_comb begin
      state_in = state_ff; base_in = base_ff; limit_in = limit_ff; brk_in = brk_ff;
      used_in = used_ff; first_in = first_ff; last_in = last_ff; cur_in = cur_ff;
      steps_in = steps_ff; slot_in = slot_ff; req_in = req_ff; rsp_in = rsp_ff;
      rspv_in = 1'b0; need_in = need_ff; ent_in = ent_ff; cidx_in = cidx_ff;
      rd_en = 1'b0; rd_addr = cur_ff[IW-1:0];
      wr_en = 1'b0; wr_addr = '0; wr_data = ent_ff;
      wr2_in = 1'b0; wa2_in = wa2_ff; wd2_in = wd2_ff;
      if (wr2_ff) begin
         wr_en = 1'b1; wr_addr = wa2_ff; wr_data = wd2_ff;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (csr_wr) begin
               if (paddr[2] == ffba_pkg::RegHeapBase) begin
                  base_in = pwdata;
                  if (first_ff == ffba_pkg::NoneIdx) brk_in = pwdata;
               end else begin
                  limit_in = pwdata;
               end
            end
            if (start) begin
               req_in = req_item;
               need_in = {7'd0, {1'b0, req_item.request_size[23:3]}
                          + 22'(req_item.request_size[2:0] != 3'd0), 3'd0};
               cur_in = first_ff; steps_in = '0; slot_in = '0;
               if (req_item.kind == ffba_pkg::KindAlloc && req_item.request_size == 24'd0)
               begin
                  rsp_in = '{32'd0, ffba_pkg::StZero}; state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (cur_ff == ffba_pkg::NoneIdx || steps_ff == PW'(ffba_pkg::MaxBlocks)) begin
               if (req_ff.kind == ffba_pkg::KindFree) begin
                  rsp_in = '{32'd0, ffba_pkg::StUnknown}; state_in = S_DONE;
               end else if (end_sum > {1'b0, limit_ff}) begin
                  rsp_in = '{32'd0, ffba_pkg::StExhausted}; state_in = S_DONE;
               end else begin
                  state_in = S_SLOT;
               end
            end else if (!wr2_ff) begin
               rd_en = 1'b1; state_in = S_CHK;
            end
         end
         S_CHK: begin
            cidx_in = cur_ff[IW-1:0];
            ent_in = rd_data;
            steps_in = steps_ff + PW'(1);
            cur_in = rd_data.succ;
            state_in = S_RD;
            if (req_ff.kind == ffba_pkg::KindAlloc) begin
               if (rd_data.is_free && rd_data.bytes >= need_ff) begin
                  wr_en = 1'b1; wr_addr = cur_ff[IW-1:0];
                  wr_data = rd_data; wr_data.is_free = 1'b0;
                  rsp_in = '{hdr_addr, ffba_pkg::StOk}; state_in = S_DONE;
               end
            end else if (hdr_addr == req_ff.payload_address) begin
               ent_in.is_free = 1'b1;
               if (rd_data.succ == ffba_pkg::NoneIdx) begin
                  state_in = S_WR;
               end else begin
                  state_in = S_NRD;
               end
            end
         end
         S_NRD: begin
            rd_en = 1'b1; rd_addr = ent_ff.succ[IW-1:0]; state_in = S_NCHK;
         end
         S_NCHK: begin
            if (rd_data.is_free) begin
               ent_in.bytes = ent_ff.bytes + 32'(ffba_pkg::HeaderBytes) + rd_data.bytes;
               ent_in.succ = rd_data.succ;
               used_in[ent_ff.succ[IW-1:0]] = 1'b0;
               if (last_ff == ent_ff.succ) last_in = {1'b0, cidx_ff};
            end
            state_in = S_WR;
         end
         S_WR: begin
            wr_en = 1'b1; wr_addr = cidx_ff; wr_data = ent_ff;
            rsp_in = '{32'd0, ffba_pkg::StOk}; state_in = S_DONE;
         end
         S_SLOT: begin
            if (slot_ff == PW'(ffba_pkg::MaxBlocks)) begin
               rsp_in = '{32'd0, ffba_pkg::StTableFull}; state_in = S_DONE;
            end else if (!used_ff[slot_ff[IW-1:0]]) begin
               used_in[slot_ff[IW-1:0]] = 1'b1;
               wr_en = 1'b1; wr_addr = slot_ff[IW-1:0];
               wr_data = '{brk_ff, need_ff, 1'b0, ffba_pkg::NoneIdx};
               if (last_ff != ffba_pkg::NoneIdx) begin
                  wr2_in = 1'b1; wa2_in = last_ff[IW-1:0];
                  wd2_in = ent_ff; wd2_in.succ = slot_ff;
               end else begin
                  first_in = slot_ff;
               end
               last_in = slot_ff;
               rsp_in = '{brk_ff + 32'(ffba_pkg::HeaderBytes), ffba_pkg::StOk};
               brk_in = end_sum[31:0];
               state_in = S_DONE;
            end else begin
               slot_in = slot_ff + PW'(1);
            end
         end
         S_DONE: begin
            rspv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; base_ff <= '0; limit_ff <= 32'd65536; brk_ff <= '0;
         used_ff <= '0; first_ff <= ffba_pkg::NoneIdx; last_ff <= ffba_pkg::NoneIdx;
         rspv_ff <= 1'b0; wr2_ff <= 1'b0;
      end else begin
         state_ff <= state_in; base_ff <= base_in; limit_ff <= limit_in;
         brk_ff <= brk_in; used_ff <= used_in; first_ff <= first_in;
         last_ff <= last_in; rspv_ff <= rspv_in; wr2_ff <= wr2_in;
      end
      cur_ff <= cur_in; steps_ff <= steps_in; slot_ff <= slot_in; req_ff <= req_in;
      rsp_ff <= rsp_in; need_ff <= need_in; ent_ff <= ent_in; cidx_ff <= cidx_in;
      wa2_ff <= wa2_in; wd2_ff <= wd2_in;
   end

   assert property (@(posedge clock) disable iff (reset) rspv_ff |-> !busy)
      else $error("response while busy");
   assert property (@(posedge clock) disable iff (reset)
      (first_ff == ffba_pkg::NoneIdx) == (last_ff == ffba_pkg::NoneIdx))
      else $error("list ends disagree");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rspv_ff)
      else $error("done without response");
   assert property (@(posedge clock) disable iff (reset)
      rspv_ff && rsp_ff.status != ffba_pkg::StOk |-> rsp_ff.granted_address == 32'd0)
      else $error("failed item with address");
endmodule
`default_nettype wire
